/* rtl/core/sif_pkg.sv */
package sif_pkg;

    localparam int Q_W       = 64;
    localparam int NRM_W     = 34;
    localparam int DIV_STEPS = 96;
    localparam int CFG_IDX_W = 3;

    localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;
    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_R = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 3'd5;

    localparam logic [62:0] TEMP_RST  = 63'd1288490188800;
    localparam logic [62:0] GAS_R_RST = 63'd1232870362317;
    localparam logic [62:0] GAMMA_RST = 63'd6012954214;

    // magnitude plus sign back to saturated two's complement
    function automatic logic [63:0] sat_mag(input logic [63:0] m, input logic neg,
                                            input logic ovf);
        logic [63:0] r;
        if (neg)
        begin
            if (ovf || (m > Q_MIN))
                r = Q_MIN;
            else
                r = ~m + 64'd1;
        end
        else
        begin
            if (ovf || m[63])
                r = Q_MAX;
            else
                r = m;
        end
        return r;
    endfunction

    function automatic logic [63:0] qadd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
            s = a[63] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    function automatic logic [63:0] qsub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if ((a[63] != b[63]) && (s[63] != a[63]))
            s = a[63] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    function automatic logic [63:0] half(input logic [63:0] x);
        return {1'b0, x[63:1]};
    endfunction

endpackage

/* rtl/core/sif_delay.sv */
module sif_delay #(
    parameter int W = 64,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[N-1];

endmodule

/* rtl/core/sif_mul.sv */
module sif_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic         neg_reg;
    logic [127:0] prod;
    logic [63:0]  p_reg;

    assign ma = a[63] ? (~a + 64'd1) : a;
    assign mb = b[63] ? (~b + 64'd1) : b;

    // 128-bit exact magnitude, Q32.32 is bits 95:32
    assign prod = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0} + {32'd0, p10_reg, 32'd0}
                + {p11_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= {32'd0, ma[31:0]}  * {32'd0, mb[31:0]};
            p01_reg <= {32'd0, ma[31:0]}  * {32'd0, mb[63:32]};
            p10_reg <= {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
            p11_reg <= {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
            neg_reg <= a[63] ^ b[63];
            p_reg   <= sif_pkg::sat_mag(prod[95:32], neg_reg, |prod[127:96]);
        end
    end

    assign p = p_reg;

endmodule

/* rtl/core/sif_div.sv */
module sif_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] q
);

    localparam int S = sif_pkg::DIV_STEPS;

    logic [63:0] rem_reg [S];
    logic [S-1:0] quo_reg [S];
    logic [63:0] ma_reg  [S];
    logic [63:0] d_reg   [S];
    logic        neg_reg [S];

    genvar k;
    generate
        for (k = 0; k < S; k++)
        begin : g_step
            logic [63:0]  rem_in;
            logic [S-1:0] quo_in;
            logic [63:0]  ma_in;
            logic [63:0]  d_in;
            logic         neg_in;
            logic         bit_in;
            logic [64:0]  t;
            logic         ge;

            if (k == 0)
            begin : g_first
                assign rem_in = 64'd0;
                assign quo_in = '0;
                assign ma_in  = a[63] ? (~a + 64'd1) : a;
                assign d_in   = b[63] ? (~b + 64'd1) : b;
                assign neg_in = a[63] ^ b[63];
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign ma_in  = ma_reg[k-1];
                assign d_in   = d_reg[k-1];
                assign neg_in = neg_reg[k-1];
            end

            if (k < 64)
            begin : g_bit
                assign bit_in = ma_in[63-k];
            end
            else
            begin : g_zero
                assign bit_in = 1'b0;
            end

            assign t  = {rem_in, bit_in};
            assign ge = (t >= {1'b0, d_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? 64'(t - {1'b0, d_in}) : t[63:0];
                    quo_reg[k] <= {quo_in[S-2:0], ge};
                    ma_reg[k]  <= ma_in;
                    d_reg[k]   <= d_in;
                    neg_reg[k] <= neg_in;
                end
            end
        end
    endgenerate

    assign q = sif_pkg::sat_mag(quo_reg[S-1][63:0], neg_reg[S-1], |quo_reg[S-1][S-1:64]);

endmodule

/* rtl/core/subsonic_inlet_face_flux.sv */
// channel   dir  group                      content
// input     in   s_axis_tvalid/tready/tdata one boundary face
// output    out  m_axis_tvalid/tready/tdata five fluxes and face tag, tuser = fault
// config    in   cfg_we/cfg_index/cfg_data  register write, no read-back
//
// One face per cycle while the output is not stalled; 209 register stages, set by two
// chained 96-step pipelined dividers (m/rho, then p/RT and p/(gamma-1)) plus
// pipelined multipliers.
// Reset clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; no request is lost or repeated.
module subsonic_inlet_face_flux #(
    parameter int FACE_ID_BITS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sif_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [63:0]                           cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // density_in, momentum_x/y/z, total_energy_in, normal_x/y/z, face_index
    input  logic [((422+FACE_ID_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // mass_flux, mom_flux_x/y/z, energy_flux, face_tag
    output logic [((320+FACE_ID_BITS+7)/8)*8-1:0] m_axis_tdata,
    // fault
    output logic                                  m_axis_tuser
);

    localparam int OUT_W = ((320+FACE_ID_BITS+7)/8)*8;
    localparam int LAT   = 209;
    localparam int FW    = FACE_ID_BITS;

    logic        adv;
    logic [LAT-1:0] valid_reg;

    logic [62:0] temp_reg;
    logic [63:0] vel_reg [3];
    logic [62:0] gas_reg;
    logic [62:0] gamma_reg;
    logic [63:0] gm1_reg;

    logic [63:0] rt;
    logic [63:0] vsq [3];
    logic [63:0] vsq_s1_reg;
    logic [63:0] vsq_z_reg;
    logic [63:0] kin_reg;

    logic [63:0] in_rho_reg;
    logic [63:0] in_m_reg [3];
    logic [63:0] in_e_reg;
    logic [sif_pkg::NRM_W-1:0] in_n_reg [3];
    logic [FW:0] in_tag_reg;

    logic [63:0] un_pr [3];
    logic [63:0] un_s1_reg;
    logic [63:0] un_z_reg;
    logic [63:0] un_reg;

    logic [63:0] vi [3];
    logic [63:0] visq [3];
    logic [63:0] ki_s1_reg;
    logic [63:0] ki_z_reg;
    logic [63:0] kin_i_reg;
    logic [63:0] rho_d101;
    logic [63:0] e_d103;
    logic [63:0] rk_i;
    logic [63:0] diff_reg;
    logic [63:0] p;

    logic [63:0] rho;
    logic [63:0] pover;
    logic [63:0] p_d202;
    logic [63:0] p_d204;
    logic [63:0] p_d205;
    logic [63:0] un_d202;
    logic [63:0] un_d204;
    logic [63:0] un_d206;
    logic [3*sif_pkg::NRM_W-1:0] n_d202;
    logic [63:0] pover_d204;
    logic [63:0] pover_fix;

    logic [63:0] mrun;
    logic [63:0] rk;
    logic [63:0] rv [3];
    logic [63:0] pn [3];
    logic [191:0] pn_d206;
    logic [63:0] ruun [3];
    logic [63:0] mom_reg [3];
    logic [191:0] mom_d208;
    logic [63:0] mrun_d208;
    logic [63:0] e_reg;
    logic [63:0] ep_reg;
    logic [63:0] ef;
    logic [FW:0] tag_d208;
    logic        fault;

    logic [63:0] out_flux_reg [5];
    logic [FW-1:0] out_face_reg;
    logic        out_fault_reg;

    assign adv           = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg   <= sif_pkg::TEMP_RST;
            vel_reg[0] <= 64'd0;
            vel_reg[1] <= 64'd0;
            vel_reg[2] <= 64'd0;
            gas_reg    <= sif_pkg::GAS_R_RST;
            gamma_reg  <= sif_pkg::GAMMA_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sif_pkg::REG_TEMP:  temp_reg   <= cfg_data[62:0];
                sif_pkg::REG_VEL_X: vel_reg[0] <= cfg_data;
                sif_pkg::REG_VEL_Y: vel_reg[1] <= cfg_data;
                sif_pkg::REG_VEL_Z: vel_reg[2] <= cfg_data;
                sif_pkg::REG_GAS_R: gas_reg    <= cfg_data[62:0];
                sif_pkg::REG_GAMMA: gamma_reg  <= cfg_data[62:0];
                default: ;
            endcase
        end
    end

    // register-derived terms, pipelined and free-running, so they lag a write
    sif_mul u_rt (.clk(clk), .en(1'b1), .a({1'b0, gas_reg}), .b({1'b0, temp_reg}), .p(rt));

    always_ff @(posedge clk)
    begin
        gm1_reg    <= {1'b0, gamma_reg} - sif_pkg::ONE_Q;
        vsq_s1_reg <= sif_pkg::qadd(vsq[0], vsq[1]);
        vsq_z_reg  <= vsq[2];
        kin_reg    <= sif_pkg::half(sif_pkg::qadd(vsq_s1_reg, vsq_z_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_rho_reg  <= s_axis_tdata[63:0];
            in_m_reg[0] <= s_axis_tdata[127:64];
            in_m_reg[1] <= s_axis_tdata[191:128];
            in_m_reg[2] <= s_axis_tdata[255:192];
            in_e_reg    <= s_axis_tdata[319:256];
            in_n_reg[0] <= s_axis_tdata[353:320];
            in_n_reg[1] <= s_axis_tdata[387:354];
            in_n_reg[2] <= s_axis_tdata[421:388];
            in_tag_reg  <= {(s_axis_tdata[63:0] == 64'd0), s_axis_tdata[421+FW:422]};
            un_s1_reg   <= sif_pkg::qadd(un_pr[0], un_pr[1]);
            un_z_reg    <= un_pr[2];
            un_reg      <= sif_pkg::qadd(un_s1_reg, un_z_reg);
            ki_s1_reg   <= sif_pkg::qadd(visq[0], visq[1]);
            ki_z_reg    <= visq[2];
            kin_i_reg   <= sif_pkg::half(sif_pkg::qadd(ki_s1_reg, ki_z_reg));
            diff_reg    <= sif_pkg::qsub(e_d103, rk_i);
            e_reg       <= sif_pkg::qadd(pover_fix, rk);
            ep_reg      <= sif_pkg::qadd(e_reg, p_d205);
        end
    end

    genvar j;
    generate
        for (j = 0; j < 3; j++)
        begin : g_axis
            sif_mul u_vsq (.clk(clk), .en(1'b1), .a(vel_reg[j]), .b(vel_reg[j]), .p(vsq[j]));
            sif_mul u_un (.clk(clk), .en(adv), .a(vel_reg[j]),
                          .b({{30{in_n_reg[j][sif_pkg::NRM_W-1]}}, in_n_reg[j]}),
                          .p(un_pr[j]));
            sif_div u_vi (.clk(clk), .en(adv), .a(in_m_reg[j]), .b(in_rho_reg), .q(vi[j]));
            sif_mul u_visq (.clk(clk), .en(adv), .a(vi[j]), .b(vi[j]), .p(visq[j]));
            sif_mul u_rv (.clk(clk), .en(adv), .a(rho), .b(vel_reg[j]), .p(rv[j]));
            sif_mul u_pn (.clk(clk), .en(adv), .a(p_d202),
                          .b({{30{n_d202[(j+1)*sif_pkg::NRM_W-1]}},
                              n_d202[j*sif_pkg::NRM_W +: sif_pkg::NRM_W]}),
                          .p(pn[j]));
            sif_mul u_ruun (.clk(clk), .en(adv), .a(rv[j]), .b(un_d204), .p(ruun[j]));

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    mom_reg[j] <= sif_pkg::qadd(pn_d206[j*64 +: 64], ruun[j]);
                end
            end
        end
    endgenerate

    sif_delay #(.W(64), .N(100)) u_rho_d (.clk(clk), .en(adv), .d(in_rho_reg), .q(rho_d101));
    sif_delay #(.W(64), .N(102)) u_e_d (.clk(clk), .en(adv), .d(in_e_reg), .q(e_d103));

    sif_mul u_rk_i (.clk(clk), .en(adv), .a(rho_d101), .b(kin_i_reg), .p(rk_i));
    sif_mul u_p (.clk(clk), .en(adv), .a(gm1_reg), .b(diff_reg), .p(p));

    sif_div u_rho (.clk(clk), .en(adv), .a(p), .b(rt), .q(rho));
    sif_div u_pover (.clk(clk), .en(adv), .a(p), .b(gm1_reg), .q(pover));

    sif_delay #(.W(64), .N(96)) u_p_d202 (.clk(clk), .en(adv), .d(p), .q(p_d202));
    sif_delay #(.W(64), .N(2)) u_p_d204 (.clk(clk), .en(adv), .d(p_d202), .q(p_d204));
    sif_delay #(.W(64), .N(1)) u_p_d205 (.clk(clk), .en(adv), .d(p_d204), .q(p_d205));
    sif_delay #(.W(64), .N(197)) u_un_d202 (.clk(clk), .en(adv), .d(un_reg), .q(un_d202));
    sif_delay #(.W(64), .N(2)) u_un_d204 (.clk(clk), .en(adv), .d(un_d202), .q(un_d204));
    sif_delay #(.W(64), .N(2)) u_un_d206 (.clk(clk), .en(adv), .d(un_d204), .q(un_d206));
    sif_delay #(.W(3*sif_pkg::NRM_W), .N(201)) u_n_d202 (
        .clk(clk), .en(adv), .d({in_n_reg[2], in_n_reg[1], in_n_reg[0]}), .q(n_d202));
    sif_delay #(.W(64), .N(2)) u_pover_d (.clk(clk), .en(adv), .d(pover), .q(pover_d204));

    // gamma of exactly one: saturate toward the sign of p, or zero when p is zero
    always_comb
    begin
        if (gm1_reg != 64'd0)
            pover_fix = pover_d204;
        else if (p_d204 == 64'd0)
            pover_fix = 64'd0;
        else
            pover_fix = p_d204[63] ? sif_pkg::Q_MIN : sif_pkg::Q_MAX;
    end

    sif_mul u_mrun (.clk(clk), .en(adv), .a(rho), .b(un_d202), .p(mrun));
    sif_mul u_rk (.clk(clk), .en(adv), .a(rho), .b(kin_reg), .p(rk));
    sif_mul u_ef (.clk(clk), .en(adv), .a(ep_reg), .b(un_d206), .p(ef));

    sif_delay #(.W(192), .N(2)) u_pn_d (.clk(clk), .en(adv), .d({pn[2], pn[1], pn[0]}),
                                        .q(pn_d206));
    sif_delay #(.W(64), .N(4)) u_mrun_d (.clk(clk), .en(adv), .d(mrun), .q(mrun_d208));
    sif_delay #(.W(192), .N(1)) u_mom_d (.clk(clk), .en(adv),
                                         .d({mom_reg[2], mom_reg[1], mom_reg[0]}),
                                         .q(mom_d208));
    sif_delay #(.W(FW+1), .N(207)) u_tag_d (.clk(clk), .en(adv), .d(in_tag_reg),
                                            .q(tag_d208));

    assign fault = tag_d208[FW] || (rt == 64'd0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_flux_reg[0] <= fault ? 64'd0 : mrun_d208;
            out_flux_reg[1] <= fault ? 64'd0 : mom_d208[63:0];
            out_flux_reg[2] <= fault ? 64'd0 : mom_d208[127:64];
            out_flux_reg[3] <= fault ? 64'd0 : mom_d208[191:128];
            out_flux_reg[4] <= fault ? 64'd0 : ef;
            out_face_reg    <= tag_d208[FW-1:0];
            out_fault_reg   <= fault;
        end
    end

    assign m_axis_tdata = OUT_W'({out_face_reg, out_flux_reg[4], out_flux_reg[3],
                                  out_flux_reg[2], out_flux_reg[1], out_flux_reg[0]});
    assign m_axis_tuser = out_fault_reg;

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[319:0] == 320'd0))
        else $error("fault result carries nonzero flux");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted request lost at entry");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

endmodule

/* verif/sif_flux_checker.sv */
module sif_flux_checker #(
    parameter int FACE_ID_BITS = 20,
    parameter int IN_W         = ((422+FACE_ID_BITS+7)/8)*8,
    parameter int OUT_W        = ((320+FACE_ID_BITS+7)/8)*8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sif_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [IN_W-1:0]                 s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [OUT_W-1:0]                m_axis_tdata,
    input  logic                            m_axis_tuser,
    output int                              errors,
    output int                              pending
);

    typedef struct packed {
        logic                    fault;
        logic [FACE_ID_BITS-1:0] tag;
        logic [63:0]             energy;
        logic [63:0]             mom_z;
        logic [63:0]             mom_y;
        logic [63:0]             mom_x;
        logic [63:0]             mass;
    } flux_t;

    logic [62:0] temp_r;
    logic [63:0] vel_x_r;
    logic [63:0] vel_y_r;
    logic [63:0] vel_z_r;
    logic [62:0] gas_r;
    logic [62:0] gamma_r;

    flux_t expected_flux[$];

    function automatic logic [63:0] mag(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic [63:0] clamp_q(input logic [63:0] m, input logic neg,
                                            input logic ovf);
        if (neg)
            return (ovf || m > sif_pkg::Q_MIN) ? sif_pkg::Q_MIN : (64'd0 - m);
        return (ovf || m[63]) ? sif_pkg::Q_MAX : m;
    endfunction

    function automatic logic [63:0] sum_q(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? sif_pkg::Q_MIN : sif_pkg::Q_MAX;
        return s;
    endfunction

    function automatic logic [63:0] diff_q(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            s = a[63] ? sif_pkg::Q_MIN : sif_pkg::Q_MAX;
        return s;
    endfunction

    function automatic logic [63:0] prod_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        return clamp_q(p[95:32], a[63] ^ b[63], |p[127:96]);
    endfunction

    // caller guarantees b != 0
    function automatic logic [63:0] quot_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] q;
        q = {32'd0, mag(a), 32'd0} / {64'd0, mag(b)};
        return clamp_q(q[63:0], a[63] ^ b[63], |q[127:64]);
    endfunction

    function automatic logic [63:0] half_sq(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] z);
        logic [63:0] s;
        s = sum_q(sum_q(prod_q(x, x), prod_q(y, y)), prod_q(z, z));
        return {1'b0, s[63:1]};
    endfunction

    function automatic flux_t face_flux(input logic [IN_W-1:0] d);
        flux_t r;
        logic [63:0] rho_i, mx, my, mz, e_i, nx, ny, nz, rt, gm1, p, rho, un, p_over, e;
        rho_i = d[63:0];
        mx    = d[127:64];
        my    = d[191:128];
        mz    = d[255:192];
        e_i   = d[319:256];
        nx    = 64'($signed(d[353:320]));
        ny    = 64'($signed(d[387:354]));
        nz    = 64'($signed(d[421:388]));
        r = '0;
        r.tag = d[422 +: FACE_ID_BITS];
        rt = prod_q({1'b0, gas_r}, {1'b0, temp_r});
        if (rho_i == 64'd0 || rt == 64'd0)
        begin
            r.fault = 1'b1;
            return r;
        end
        gm1 = {1'b0, gamma_r} - sif_pkg::ONE_Q;
        p = prod_q(gm1, diff_q(e_i, prod_q(rho_i,
                half_sq(quot_q(mx, rho_i), quot_q(my, rho_i), quot_q(mz, rho_i)))));
        rho = quot_q(p, rt);
        un = sum_q(sum_q(prod_q(vel_x_r, nx), prod_q(vel_y_r, ny)), prod_q(vel_z_r, nz));
        if (gm1 != 64'd0)
            p_over = quot_q(p, gm1);
        else
            p_over = (p == 64'd0) ? 64'd0 : (p[63] ? sif_pkg::Q_MIN : sif_pkg::Q_MAX);
        e = sum_q(p_over, prod_q(rho, half_sq(vel_x_r, vel_y_r, vel_z_r)));
        r.mass   = prod_q(rho, un);
        r.mom_x  = sum_q(prod_q(p, nx), prod_q(prod_q(rho, vel_x_r), un));
        r.mom_y  = sum_q(prod_q(p, ny), prod_q(prod_q(rho, vel_y_r), un));
        r.mom_z  = sum_q(prod_q(p, nz), prod_q(prod_q(rho, vel_z_r), un));
        r.energy = prod_q(sum_q(e, p), un);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flux_t want;
        flux_t got;
        if (!rst_n)
        begin
            temp_r  <= sif_pkg::TEMP_RST;
            vel_x_r <= '0;
            vel_y_r <= '0;
            vel_z_r <= '0;
            gas_r   <= sif_pkg::GAS_R_RST;
            gamma_r <= sif_pkg::GAMMA_RST;
            errors  = 0;
            expected_flux.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sif_pkg::REG_TEMP:  temp_r  <= cfg_data[62:0];
                    sif_pkg::REG_VEL_X: vel_x_r <= cfg_data;
                    sif_pkg::REG_VEL_Y: vel_y_r <= cfg_data;
                    sif_pkg::REG_VEL_Z: vel_z_r <= cfg_data;
                    sif_pkg::REG_GAS_R: gas_r   <= cfg_data[62:0];
                    sif_pkg::REG_GAMMA: gamma_r <= cfg_data[62:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_flux.push_back(face_flux(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[320 +: FACE_ID_BITS], m_axis_tdata[319:0]};
                if (expected_flux.size() == 0)
                begin
                    $error("unexpected request on output, tag %0h", got.tag);
                    errors++;
                end
                else
                begin
                    want = expected_flux.pop_front();
                    if (got.mass !== want.mass)
                    begin
                        $error("mass_flux exp %h got %h", want.mass, got.mass);
                        errors++;
                    end
                    if (got.mom_x !== want.mom_x)
                    begin
                        $error("mom_flux_x exp %h got %h", want.mom_x, got.mom_x);
                        errors++;
                    end
                    if (got.mom_y !== want.mom_y)
                    begin
                        $error("mom_flux_y exp %h got %h", want.mom_y, got.mom_y);
                        errors++;
                    end
                    if (got.mom_z !== want.mom_z)
                    begin
                        $error("mom_flux_z exp %h got %h", want.mom_z, got.mom_z);
                        errors++;
                    end
                    if (got.energy !== want.energy)
                    begin
                        $error("energy_flux exp %h got %h", want.energy, got.energy);
                        errors++;
                    end
                    if (got.tag !== want.tag)
                    begin
                        $error("face_tag exp %h got %h", want.tag, got.tag);
                        errors++;
                    end
                    if (got.fault !== want.fault)
                    begin
                        $error("fault exp %b got %b", want.fault, got.fault);
                        errors++;
                    end
                end
            end
        end
    end

    assign pending = expected_flux.size();

endmodule

/* verif/tb_subsonic_inlet_face_flux.sv */
module tb_subsonic_inlet_face_flux;

    localparam int FACE_ID_BITS = 20;
    localparam int IN_W         = ((422+FACE_ID_BITS+7)/8)*8;
    localparam int OUT_W        = ((320+FACE_ID_BITS+7)/8)*8;
    localparam int LATENCY      = 240;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam logic [sif_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [sif_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [63:0] NRM_POS = 64'h0000_0001_0000_0000;
    localparam logic [63:0] NRM_NEG = 64'hFFFF_FFFF_0000_0000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [sif_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]                   cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_W-1:0]               s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [OUT_W-1:0]              m_axis_tdata;
    logic                          m_axis_tuser;
    int                            errors;
    int                            pending;
    int                            sent = 0;
    int                            cycles = 0;

    subsonic_inlet_face_flux #(.FACE_ID_BITS(FACE_ID_BITS)) dut (.*);

    sif_flux_checker #(.FACE_ID_BITS(FACE_ID_BITS)) u_checker (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_subsonic_inlet_face_flux failed");
            $finish;
        end
    end

    function automatic bit calm();
        return sent >= 400 && sent < 550;
    endfunction

    // output side: random stalls, one long hold-off once the pipe holds traffic
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent >= 100)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                for (n = 0; n < 700; n++)
                    @(posedge clk);
            end
            m_axis_tready <= calm() || ($urandom_range(0, 99) >= 35);
        end
    end

    task automatic set_reg(input logic [sif_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic end_regs();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [33:0] rnd_normal();
        longint v;
        if ($urandom_range(0, 9) == 0)
            return 34'({$urandom, $urandom});
        v = ((longint'($urandom) << 1) | longint'($urandom_range(0, 1))) - 64'sd4294967296;
        return 34'(v);
    endfunction

    task automatic send_face(input logic [63:0] rho, input logic [63:0] mx,
                             input logic [63:0] my, input logic [63:0] mz,
                             input logic [63:0] e, input logic [33:0] nx,
                             input logic [33:0] ny, input logic [33:0] nz,
                             input logic [FACE_ID_BITS-1:0] face);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({face, nz, ny, nx, e, mz, my, mx, rho});
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        sent++;
        if (!calm() && $urandom_range(0, 99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic [63:0] rho, mx, my, mz, e;
        if ($urandom_range(0, 9) < 7)
        begin
            rho = {32'($urandom_range(1, 100)), $urandom};
            mx  = ((64'($urandom_range(0, 2000)) << 32) | 64'($urandom)) - (64'd1000 << 32);
            my  = ((64'($urandom_range(0, 2000)) << 32) | 64'($urandom)) - (64'd1000 << 32);
            mz  = ((64'($urandom_range(0, 2000)) << 32) | 64'($urandom)) - (64'd1000 << 32);
            e   = {32'($urandom_range(100, 1000000)), $urandom};
        end
        else
        begin
            rho = rnd64();
            mx  = rnd64();
            my  = rnd64();
            mz  = rnd64();
            e   = rnd64();
        end
        send_face(rho, mx, my, mz, e, rnd_normal(), rnd_normal(), rnd_normal(),
                  FACE_ID_BITS'($urandom));
    endtask

    task automatic random_regs();
        set_reg(sif_pkg::REG_TEMP,  {1'b0, 31'($urandom_range(1, 2000)), $urandom});
        set_reg(sif_pkg::REG_VEL_X,
                ((64'($urandom_range(0, 800)) << 32) | 64'($urandom)) - (64'd400 << 32));
        set_reg(sif_pkg::REG_VEL_Y,
                ((64'($urandom_range(0, 800)) << 32) | 64'($urandom)) - (64'd400 << 32));
        set_reg(sif_pkg::REG_VEL_Z,
                ((64'($urandom_range(0, 800)) << 32) | 64'($urandom)) - (64'd400 << 32));
        set_reg(sif_pkg::REG_GAS_R, {1'b0, 31'($urandom_range(1, 2000)), $urandom});
        set_reg(sif_pkg::REG_GAMMA, {31'd0, 1'b1, $urandom});
        end_regs();
    endtask

    task automatic burst(input int n);
        repeat (n) send_random();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed faces at reset registers
        send_face(64'd0, rnd64(), rnd64(), rnd64(), rnd64(), 34'(NRM_POS), 34'd0, 34'd0,
                  '1);
        send_face(sif_pkg::Q_MAX, sif_pkg::Q_MAX, sif_pkg::Q_MAX, sif_pkg::Q_MAX,
                  sif_pkg::Q_MAX, 34'(NRM_POS), 34'(NRM_POS), 34'(NRM_POS), '0);
        send_face(sif_pkg::Q_MIN, sif_pkg::Q_MIN, sif_pkg::Q_MIN, sif_pkg::Q_MIN,
                  sif_pkg::Q_MIN, 34'(NRM_NEG), 34'(NRM_NEG), 34'(NRM_NEG), 20'h5_5555);
        send_face(64'd1, sif_pkg::Q_MAX, sif_pkg::Q_MIN, 64'd1, 64'd0, 34'h2_0000_0000,
                  34'h1_FFFF_FFFF, 34'd0, 20'hA_AAAA);
        send_face(NRM_NEG, 64'd0, 64'd0, 64'd0, 64'd1 << 40, 34'd0, 34'(NRM_POS), 34'd0, 20'd7);
        send_face(sif_pkg::ONE_Q, sif_pkg::ONE_Q, 64'd0, 64'd0, 64'd10 << 32, 34'(NRM_NEG),
                  34'd0, 34'(NRM_POS), 20'd8);
        settle();

        // high velocities, extreme registers
        set_reg(sif_pkg::REG_VEL_X, sif_pkg::Q_MAX);
        set_reg(sif_pkg::REG_VEL_Y, sif_pkg::Q_MIN);
        set_reg(sif_pkg::REG_VEL_Z, 64'd100 << 32);
        set_reg(sif_pkg::REG_TEMP, {1'b0, sif_pkg::Q_MAX[62:0]});
        set_reg(sif_pkg::REG_GAS_R, {1'b0, sif_pkg::Q_MAX[62:0]});
        set_reg(sif_pkg::REG_GAMMA, {1'b0, sif_pkg::Q_MAX[62:0]});
        end_regs();
        send_face(sif_pkg::ONE_Q, sif_pkg::ONE_Q, sif_pkg::ONE_Q, sif_pkg::ONE_Q,
                  64'd1000 << 32, 34'(NRM_POS), 34'(NRM_NEG), 34'd0, 20'd1);
        send_face(sif_pkg::Q_MAX, 64'd0, 64'd0, 64'd0, sif_pkg::Q_MAX, 34'(NRM_NEG),
                  34'(NRM_POS), 34'(NRM_POS), 20'd2);
        burst(50);
        settle();

        // R*T underflows to zero; spare indexes must be ignored
        set_reg(sif_pkg::REG_TEMP, 64'd1);
        set_reg(sif_pkg::REG_GAS_R, 64'd1);
        set_reg(REG_SPARE_6, rnd64());
        set_reg(REG_SPARE_7, rnd64());
        end_regs();
        send_face(sif_pkg::ONE_Q, sif_pkg::ONE_Q, sif_pkg::ONE_Q, sif_pkg::ONE_Q,
                  sif_pkg::ONE_Q, 34'(NRM_POS), 34'd0, 34'd0, 20'd3);
        burst(40);
        settle();

        // gamma exactly one, then below one
        random_regs();
        set_reg(sif_pkg::REG_GAMMA, sif_pkg::ONE_Q);
        end_regs();
        send_face(sif_pkg::ONE_Q, 64'd0, 64'd0, 64'd0, 64'd0, 34'(NRM_POS), 34'd0, 34'd0,
                  20'd4);
        send_face(sif_pkg::ONE_Q, 64'd0, 64'd0, 64'd0, 64'd5 << 32, 34'(NRM_POS), 34'd0,
                  34'd0, 20'd5);
        send_face(sif_pkg::ONE_Q, 64'd0, 64'd0, 64'd0, NRM_NEG, 34'(NRM_POS), 34'd0, 34'd0,
                  20'd6);
        burst(50);
        settle();
        set_reg(sif_pkg::REG_GAMMA, 64'h0000_0000_8000_0000);
        end_regs();
        burst(50);
        settle();

        random_regs();
        burst(300);
        settle();
        random_regs();
        burst(150);
        settle();
        random_regs();
        set_reg(sif_pkg::REG_TEMP, 64'(sif_pkg::TEMP_RST));
        set_reg(sif_pkg::REG_GAS_R, 64'(sif_pkg::GAS_R_RST));
        set_reg(sif_pkg::REG_GAMMA, 64'(sif_pkg::GAMMA_RST));
        end_regs();
        burst(100);
        settle();

        if (errors == 0)
            $display("tb_subsonic_inlet_face_flux passed");
        else
            $display("tb_subsonic_inlet_face_flux failed");
        $finish;
    end

endmodule
